>>> hdl/gbs_pkg.sv
`default_nettype none

package gbs_pkg;

    // Field widths
    localparam int DIM_W   = 16;           // input coordinate and size fields
    localparam int COORD_W = 18;           // box edges, exact for left + width
    localparam int AREA_W  = 32;           // width * height
    localparam int SUM_W   = 33;           // sum of two areas, union
    localparam int THR_W   = 16;           // Q0.16 overlap limit
    localparam int PROD_W  = 49;           // threshold * union
    localparam int IDX_W   = 10;           // box index in the result

    // Overlap limit after reset, about 0.45 in Q0.16
    localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Compare pipeline: read, edges, intersection, union, product
    localparam int PIPE_LEN = 5;

    // One box with its derived corners and area
    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic [AREA_W-1:0]         area;
    } box_t;

    // Queue entry passed from front to back
    typedef struct packed {
        box_t             box;
        logic [IDX_W-1:0] index;
        logic             frame_end;
    } item_t;

    // Result held in the output register
    typedef struct packed {
        logic             keep;
        logic [IDX_W-1:0] index;
        logic             store_full;
        logic             frame_last;
    } result_t;

    // Back-end sequencer
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SWEEP  = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } back_state_t;

endpackage

`default_nettype wire

>>> hdl/gbs_queue.sv
`default_nettype none

module gbs_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  gbs_pkg::item_t      push_data,
    output logic                full,
    input  wire logic           pop,
    output gbs_pkg::item_t      pop_data,
    output logic                empty
);

    gbs_pkg::item_t                 entry_reg [gbs_pkg::QUEUE_DEPTH];
    logic [gbs_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [gbs_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [gbs_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign full     = (count_reg == gbs_pkg::QCNT_W'(gbs_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/gbs_front.sv
`default_nettype none

module gbs_front #(
    parameter int BOX_MAX = 1024
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [gbs_pkg::DIM_W-1:0] box_left,
    input  wire logic signed [gbs_pkg::DIM_W-1:0] box_top,
    input  wire logic [gbs_pkg::DIM_W-1:0]      box_width,
    input  wire logic [gbs_pkg::DIM_W-1:0]      box_height,
    input  wire logic                           frame_end,
    input  wire logic                           q_full,
    output logic                                q_push,
    output gbs_pkg::item_t                      q_data
);

    localparam int CNT_W = $clog2(BOX_MAX);

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;

    // Form corners and area of the incoming box
    always_comb
    begin
        q_data.box.x0   = gbs_pkg::COORD_W'(box_left);
        q_data.box.y0   = gbs_pkg::COORD_W'(box_top);
        q_data.box.x1   = gbs_pkg::COORD_W'(box_left)
                        + $signed(gbs_pkg::COORD_W'(box_width));
        q_data.box.y1   = gbs_pkg::COORD_W'(box_top)
                        + $signed(gbs_pkg::COORD_W'(box_height));
        q_data.box.area = gbs_pkg::AREA_W'(box_width) * gbs_pkg::AREA_W'(box_height);
        q_data.index     = gbs_pkg::IDX_W'(idx_reg);
        q_data.frame_end = frame_end;
    end

    // Advance the box index, restart it at the end of a frame or after BOX_MAX - 1
    always_comb
    begin
        idx_next = idx_reg;
        if (accept)
        begin
            if (frame_end || idx_reg == CNT_W'(BOX_MAX - 1))
            begin
                idx_next = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/gbs_back.sv
`default_nettype none

module gbs_back #(
    parameter int KEEP_MAX = 256
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [gbs_pkg::THR_W-1:0]  thr,
    input  wire logic                       q_empty,
    output logic                            q_pop,
    input  gbs_pkg::item_t                  q_data,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output gbs_pkg::result_t                result
);

    localparam int AW    = (KEEP_MAX > 1) ? $clog2(KEEP_MAX) : 1;
    localparam int CNT_W = $clog2(KEEP_MAX + 1);

    gbs_pkg::box_t                  kept_mem [KEEP_MAX];

    gbs_pkg::back_state_t           state_reg, state_next;
    gbs_pkg::item_t                 cur_reg;
    logic [CNT_W-1:0]               rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0]               kept_count_reg, kept_count_next;
    logic [gbs_pkg::PIPE_LEN-1:0]   pipe_v_reg, pipe_v_next;
    logic                           suppress_reg, suppress_next;
    logic                           out_valid_reg, out_valid_next;
    gbs_pkg::result_t               result_reg;

    // Compare pipeline payload
    gbs_pkg::box_t                  rd_data_reg;
    logic [gbs_pkg::DIM_W-1:0]      iw_reg, ih_reg;
    logic [gbs_pkg::SUM_W-1:0]      sum2_reg, sum3_reg;
    logic [gbs_pkg::AREA_W-1:0]     inter3_reg, inter4_reg, inter5_reg;
    logic [gbs_pkg::SUM_W-1:0]      uni4_reg;
    logic [gbs_pkg::PROD_W-1:0]     prod5_reg;

    logic                           issue;
    logic                           wr_en;
    logic                           load_out;
    logic                           keep_c;
    logic                           full_c;
    logic                           hit;
    logic                           pipe_busy;

    logic signed [gbs_pkg::COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [gbs_pkg::COORD_W:0]   iw_w, ih_w;
    logic [gbs_pkg::DIM_W-1:0]          iw_c, ih_c;

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign pipe_busy = |pipe_v_reg;
    assign keep_c    = !suppress_reg;
    assign full_c    = (kept_count_reg == CNT_W'(KEEP_MAX));
    assign hit       = gbs_pkg::PROD_W'({inter5_reg, 16'h0000}) > prod5_reg;

    // Sequence one box: sweep the store, drain the pipeline, report
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        issue      = 1'b0;
        wr_en      = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            gbs_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = gbs_pkg::ST_SWEEP;
                end
            end
            gbs_pkg::ST_SWEEP:
            begin
                if (rd_addr_reg == kept_count_reg)
                begin
                    state_next = gbs_pkg::ST_DRAIN;
                end
                else
                begin
                    issue = 1'b1;
                end
            end
            gbs_pkg::ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = gbs_pkg::ST_FINISH;
                end
            end
            gbs_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    wr_en      = keep_c && !full_c;
                    state_next = gbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gbs_pkg::ST_IDLE;
            end
        endcase
    end

    // Update sweep address, hit flag, store count and output valid
    always_comb
    begin
        rd_addr_next = rd_addr_reg;
        if (q_pop)
        begin
            rd_addr_next = '0;
        end
        else if (issue)
        begin
            rd_addr_next = rd_addr_reg + 1'b1;
        end

        pipe_v_next = {pipe_v_reg[gbs_pkg::PIPE_LEN-2:0], issue};

        suppress_next = suppress_reg;
        if (q_pop)
        begin
            suppress_next = 1'b0;
        end
        else if (pipe_v_reg[gbs_pkg::PIPE_LEN-1] && hit)
        begin
            suppress_next = 1'b1;
        end

        kept_count_next = kept_count_reg;
        if (load_out)
        begin
            if (cur_reg.frame_end)
            begin
                kept_count_next = '0;
            end
            else if (wr_en)
            begin
                kept_count_next = kept_count_reg + 1'b1;
            end
        end

        out_valid_next = out_valid_reg && out_stall;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gbs_pkg::ST_IDLE;
            rd_addr_reg    <= '0;
            kept_count_reg <= '0;
            pipe_v_reg     <= '0;
            suppress_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_addr_reg    <= rd_addr_next;
            kept_count_reg <= kept_count_next;
            pipe_v_reg     <= pipe_v_next;
            suppress_reg   <= suppress_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold the current box and the result
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
        if (load_out)
        begin
            result_reg.keep       <= keep_c;
            result_reg.index      <= cur_reg.index;
            result_reg.store_full <= keep_c && full_c;
            result_reg.frame_last <= cur_reg.frame_end;
        end
    end

    // Kept-box store: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            kept_mem[kept_count_reg[AW-1:0]] <= cur_reg.box;
        end
        if (issue)
        begin
            rd_data_reg <= kept_mem[rd_addr_reg[AW-1:0]];
        end
    end

    // Clip the overlap extents to zero when the boxes do not overlap
    always_comb
    begin
        lo_x = (cur_reg.box.x0 > rd_data_reg.x0) ? cur_reg.box.x0 : rd_data_reg.x0;
        hi_x = (cur_reg.box.x1 < rd_data_reg.x1) ? cur_reg.box.x1 : rd_data_reg.x1;
        lo_y = (cur_reg.box.y0 > rd_data_reg.y0) ? cur_reg.box.y0 : rd_data_reg.y0;
        hi_y = (cur_reg.box.y1 < rd_data_reg.y1) ? cur_reg.box.y1 : rd_data_reg.y1;
        iw_w = (gbs_pkg::COORD_W+1)'(hi_x) - (gbs_pkg::COORD_W+1)'(lo_x);
        ih_w = (gbs_pkg::COORD_W+1)'(hi_y) - (gbs_pkg::COORD_W+1)'(lo_y);
        iw_c = (iw_w > 0) ? iw_w[gbs_pkg::DIM_W-1:0] : '0;
        ih_c = (ih_w > 0) ? ih_w[gbs_pkg::DIM_W-1:0] : '0;
    end

    // Advance the compare pipeline: extents, intersection, union, product
    always_ff @(posedge clk)
    begin
        iw_reg     <= iw_c;
        ih_reg     <= ih_c;
        sum2_reg   <= gbs_pkg::SUM_W'(cur_reg.box.area) + gbs_pkg::SUM_W'(rd_data_reg.area);
        inter3_reg <= gbs_pkg::AREA_W'(iw_reg) * gbs_pkg::AREA_W'(ih_reg);
        sum3_reg   <= sum2_reg;
        uni4_reg   <= sum3_reg - gbs_pkg::SUM_W'(inter3_reg);
        inter4_reg <= inter3_reg;
        prod5_reg  <= gbs_pkg::PROD_W'(thr) * gbs_pkg::PROD_W'(uni4_reg);
        inter5_reg <= inter4_reg;
    end

endmodule

`default_nettype wire

>>> hdl/greedy_box_suppression.sv
`default_nettype none

// Greedy box suppression by overlap ratio. Boxes arrive sorted by falling
// score; each is checked against every box kept so far in its frame and is
// dropped when intersection * 65536 exceeds iou_threshold * union. One result
// comes out per box, in order. The front end takes a box into a two-entry
// queue while the back end works, so input transfers continue while a result
// waits. The back end reads the kept-box memory one entry a cycle through a
// five-stage compare pipeline. For each box the back end takes it from the
// queue, sweeps the kept entries, drains the pipeline and loads the result;
// the load waits while the result before it is still held by a stalled
// output. A box flagged frame_end empties the store and restarts the box
// index. The store needs no clearing after reset.
module greedy_box_suppression #(
    parameter int KEEP_MAX = 256,
    parameter int BOX_MAX  = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [gbs_pkg::THR_W-1:0]          cfg_wdata,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic signed [gbs_pkg::DIM_W-1:0]   box_left,
    input  wire logic signed [gbs_pkg::DIM_W-1:0]   box_top,
    input  wire logic [gbs_pkg::DIM_W-1:0]          box_width,
    input  wire logic [gbs_pkg::DIM_W-1:0]          box_height,
    input  wire logic                               frame_end,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    keep,
    output logic [gbs_pkg::IDX_W-1:0]               box_index,
    output logic                                    store_full,
    output logic                                    frame_last
);

    logic [gbs_pkg::THR_W-1:0]  thr_reg, thr_next;
    gbs_pkg::item_t             push_data;
    gbs_pkg::item_t             pop_data;
    gbs_pkg::result_t           result;
    logic                       q_push, q_full, q_pop, q_empty;

    // Hold the overlap threshold
    assign thr_next = cfg_we ? cfg_wdata : thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= gbs_pkg::THR_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    gbs_front #(
        .BOX_MAX (BOX_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .box_left   (box_left),
        .box_top    (box_top),
        .box_width  (box_width),
        .box_height (box_height),
        .frame_end  (frame_end),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (push_data)
    );

    gbs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    gbs_back #(
        .KEEP_MAX (KEEP_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .thr       (thr_reg),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_data    (pop_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign keep       = result.keep;
    assign box_index  = result.index;
    assign store_full = result.store_full;
    assign frame_last = result.frame_last;

endmodule

`default_nettype wire

>>> hdl/gbs_checker.sv
`default_nettype none

module gbs_checker #(
    parameter int BOX_MAX = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       out_valid,
    input  wire logic                       out_stall,
    input  wire logic                       keep,
    input  wire logic [gbs_pkg::IDX_W-1:0]  box_index,
    input  wire logic                       store_full,
    input  wire logic                       frame_last
);

    localparam int CNT_W = $clog2(BOX_MAX);

    logic [CNT_W-1:0]   exp_idx_reg, exp_idx_next;
    logic               first_reg, first_next;
    logic               out_xfer;

    assign out_xfer = out_valid && !out_stall;

    // Track the index and frame start expected for the next result
    always_comb
    begin
        exp_idx_next = exp_idx_reg;
        first_next   = first_reg;
        if (out_xfer)
        begin
            first_next = frame_last;
            if (frame_last || exp_idx_reg == CNT_W'(BOX_MAX - 1))
            begin
                exp_idx_next = '0;
            end
            else
            begin
                exp_idx_next = exp_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= '0;
            first_reg   <= 1'b1;
        end
        else
        begin
            exp_idx_reg <= exp_idx_next;
            first_reg   <= first_next;
        end
    end

    // A stalled result stays and holds its fields
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable({keep, box_index, store_full, frame_last}))
        else $error("stalled result changed or dropped");

    // Results are numbered in order within a frame
    a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> box_index == gbs_pkg::IDX_W'(exp_idx_reg))
        else $error("result index out of sequence");

    // The first box of a frame meets an empty store
    a_first_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && first_reg |-> keep && !store_full)
        else $error("first box of frame not kept");

    // A dropped box never reports a full store
    a_full_needs_keep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && store_full |-> keep)
        else $error("store full reported on a dropped box");

endmodule

bind greedy_box_suppression gbs_checker #(
    .BOX_MAX (BOX_MAX)
) u_gbs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .keep       (keep),
    .box_index  (box_index),
    .store_full (store_full),
    .frame_last (frame_last)
);

`default_nettype wire

>>> test/suppression_checker.sv
`default_nettype none

module suppression_checker #(
    parameter int KEEP_MAX = 256,
    parameter int BOX_MAX  = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [gbs_pkg::THR_W-1:0]          cfg_wdata,
    input  wire logic                               in_valid,
    input  wire logic                               in_stall,
    input  wire logic signed [gbs_pkg::DIM_W-1:0]   box_left,
    input  wire logic signed [gbs_pkg::DIM_W-1:0]   box_top,
    input  wire logic [gbs_pkg::DIM_W-1:0]          box_width,
    input  wire logic [gbs_pkg::DIM_W-1:0]          box_height,
    input  wire logic                               frame_end,
    input  wire logic                               out_valid,
    input  wire logic                               out_stall,
    input  wire logic                               keep,
    input  wire logic [gbs_pkg::IDX_W-1:0]          box_index,
    input  wire logic                               store_full,
    input  wire logic                               frame_last,
    output int                                      mismatches,
    output int                                      outstanding
);

    // Box held as exact corners and area
    typedef struct {
        longint x0;
        longint y0;
        longint x1;
        longint y1;
        longint area;
    } rect_t;

    typedef struct {
        logic                      keep;
        logic [gbs_pkg::IDX_W-1:0] index;
        logic                      full;
        logic                      last;
    } verdict_t;

    rect_t                     kept_rects [KEEP_MAX];
    int                        kept_total;
    int                        frame_pos;
    logic [gbs_pkg::THR_W-1:0] iou_limit;
    verdict_t                  expected_verdicts [$];
    int                        fail_total;
    verdict_t                  due;
    rect_t                     arriving;

    // Overlap area; strictly separate or touching boxes give zero
    function automatic longint overlap_area(input rect_t a, input rect_t b);
        longint iw;
        longint ih;
        if (a.x0 > b.x1 || a.x1 < b.x0 || a.y0 > b.y1 || a.y1 < b.y0)
            return 0;
        iw = ((a.x1 < b.x1) ? a.x1 : b.x1) - ((a.x0 > b.x0) ? a.x0 : b.x0);
        ih = ((a.y1 < b.y1) ? a.y1 : b.y1) - ((a.y0 > b.y0) ? a.y0 : b.y0);
        if (iw <= 0 || ih <= 0)
            return 0;
        return iw * ih;
    endfunction

    // Test one box against the kept store, then advance the frame state
    function automatic verdict_t judge_box(input rect_t cur, input logic fend);
        verdict_t v;
        longint   inter;
        longint   uni;
        v.keep  = 1'b1;
        v.full  = 1'b0;
        v.index = frame_pos[gbs_pkg::IDX_W-1:0];
        v.last  = fend;
        for (int j = 0; j < kept_total; j++)
        begin
            inter = overlap_area(cur, kept_rects[j]);
            uni   = cur.area + kept_rects[j].area - inter;
            if (inter * 65536 > longint'(iou_limit) * uni)
                v.keep = 1'b0;
        end
        if (v.keep)
        begin
            if (kept_total < KEEP_MAX)
            begin
                kept_rects[kept_total] = cur;
                kept_total++;
            end
            else
                v.full = 1'b1;
        end
        if (fend)
        begin
            kept_total = 0;
            frame_pos  = 0;
        end
        else
            frame_pos = (frame_pos + 1) % BOX_MAX;
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_total = 0;
            frame_pos  = 0;
            iou_limit  = gbs_pkg::THR_RESET;
            fail_total = 0;
            expected_verdicts.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                iou_limit = cfg_wdata;

            // Check each result transfer against the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("unexpected result: keep %0b index %0d full %0b last %0b",
                                 keep, box_index, store_full, frame_last);
                end
                else
                begin
                    due = expected_verdicts.pop_front();
                    if (due.keep !== keep || due.index !== box_index ||
                        due.full !== store_full || due.last !== frame_last)
                    begin
                        fail_total++;
                        if (fail_total <= 10)
                        begin
                            $display("mismatch: expected keep %0b index %0d full %0b last %0b",
                                     due.keep, due.index, due.full, due.last);
                            $display("          got keep %0b index %0d full %0b last %0b",
                                     keep, box_index, store_full, frame_last);
                        end
                    end
                end
            end

            // Predict the result of each box transfer
            if (in_valid && !in_stall)
            begin
                arriving.x0   = longint'(box_left);
                arriving.y0   = longint'(box_top);
                arriving.x1   = arriving.x0 + longint'(box_width);
                arriving.y1   = arriving.y0 + longint'(box_height);
                arriving.area = longint'(box_width) * longint'(box_height);
                expected_verdicts.insert(expected_verdicts.size(),
                                         judge_box(arriving, frame_end));
            end

            mismatches  <= fail_total;
            outstanding <= expected_verdicts.size();
        end
    end

endmodule

`default_nettype wire

>>> test/greedy_box_suppression_tb.sv
`default_nettype none

module greedy_box_suppression_tb;

    localparam int KEEP_MAX = 256;
    localparam int BOX_MAX  = 1024;

    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_ALTERNATE
    } rx_mode_t;

    logic                                   clk        = 1'b0;
    logic                                   rst_n      = 1'b0;
    logic                                   cfg_we     = 1'b0;
    logic [gbs_pkg::THR_W-1:0]              cfg_wdata  = '0;
    logic                                   in_valid   = 1'b0;
    logic signed [gbs_pkg::DIM_W-1:0]       box_left   = '0;
    logic signed [gbs_pkg::DIM_W-1:0]       box_top    = '0;
    logic [gbs_pkg::DIM_W-1:0]              box_width  = '0;
    logic [gbs_pkg::DIM_W-1:0]              box_height = '0;
    logic                                   frame_end  = 1'b0;
    logic                                   out_stall  = 1'b0;
    logic                                   in_stall;
    logic                                   out_valid;
    logic                                   keep;
    logic [gbs_pkg::IDX_W-1:0]              box_index;
    logic                                   store_full;
    logic                                   frame_last;
    int                                     mismatches;
    int                                     outstanding;

    int       burst_left   = 0;
    rx_mode_t rx_mode      = RX_FREE;
    int       rx_mode_left = 0;
    int       rx_hold_left = 0;
    bit       rx_hold_done = 1'b0;
    int       rx_taken     = 0;

    greedy_box_suppression #(
        .KEEP_MAX (KEEP_MAX),
        .BOX_MAX  (BOX_MAX)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .box_left   (box_left),
        .box_top    (box_top),
        .box_width  (box_width),
        .box_height (box_height),
        .frame_end  (frame_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .keep       (keep),
        .box_index  (box_index),
        .store_full (store_full),
        .frame_last (frame_last)
    );

    suppression_checker #(
        .KEEP_MAX (KEEP_MAX),
        .BOX_MAX  (BOX_MAX)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .box_left    (box_left),
        .box_top     (box_top),
        .box_width   (box_width),
        .box_height  (box_height),
        .frame_end   (frame_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .keep        (keep),
        .box_index   (box_index),
        .store_full  (store_full),
        .frame_last  (frame_last),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop if the run hangs
    initial
    begin
        #30000000;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: stall patterns of varying density, with one long hold-off after 150 results
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            rx_taken++;
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            out_stall <= 1'b1;
        end
        else if (!rx_hold_done && rx_taken >= 150)
        begin
            rx_hold_done = 1'b1;
            rx_hold_left = 1500;
            out_stall <= 1'b1;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(20, 300);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_FREE:  out_stall <= 1'b0;
                RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:  out_stall <= !out_stall;
            endcase
        end
    end

    // Hold until every predicted result has been taken
    task automatic wait_drained();
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_threshold(input int value);
        cfg_wdata <= value[gbs_pkg::THR_W-1:0];
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Drop valid, let the block drain, then load a new overlap limit
    task automatic start_phase(input int value);
        in_valid <= 1'b0;
        wait_drained();
        write_threshold(value);
        burst_left = 0;
    endtask

    // Offer one box in bursts with gaps; return once the transfer is taken
    task automatic send_box(input int l, input int t, input int w, input int h, input bit fe);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 24) == 0)
                wait_drained();
            else
                repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        box_left   <= l[gbs_pkg::DIM_W-1:0];
        box_top    <= t[gbs_pkg::DIM_W-1:0];
        box_width  <= w[gbs_pkg::DIM_W-1:0];
        box_height <= h[gbs_pkg::DIM_W-1:0];
        frame_end  <= fe;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Short frames of boxes clustered round a random centre
    task automatic run_clustered_frames(input int item_goal);
        int sent;
        int len;
        int cx;
        int cy;
        int pick;
        int l;
        int t;
        int w;
        int h;
        sent = 0;
        l = 0;
        t = 0;
        w = 0;
        h = 0;
        while (sent < item_goal)
        begin
            len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
            cx  = $urandom_range(0, 60000) - 30000;
            cy  = $urandom_range(0, 60000) - 30000;
            for (int i = 0; i < len; i++)
            begin
                pick = $urandom_range(0, 15);
                if (pick == 0)
                begin
                    l = $urandom;
                    t = $urandom;
                    w = $urandom;
                    h = $urandom;
                end
                else if (pick == 1 && i > 0)
                begin
                    // repeat the previous box unchanged
                end
                else
                begin
                    l = cx + $urandom_range(0, 800) - 400;
                    t = cy + $urandom_range(0, 800) - 400;
                    w = (pick == 2) ? 0 : $urandom_range(1, 800);
                    h = $urandom_range(0, 800);
                end
                send_box(l, t, w, h, i == len - 1);
            end
            sent += len;
        end
    endtask

    // One long frame: fill the store with separate boxes, then overflow it
    // and run the box index past its wrap
    task automatic run_crowded_frame(input int len);
        int px [300];
        int py [300];
        int pw [300];
        int ph [300];
        int l;
        int t;
        int w;
        int h;
        int src;
        int pick;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 15);
            if (i < 300)
            begin
                if (i % 10 == 9)
                begin
                    src = $urandom_range(0, i - 1);
                    l = px[src];
                    t = py[src];
                    w = pw[src];
                    h = ph[src];
                end
                else
                begin
                    l = -32768 + (i % 32) * 2048 + $urandom_range(0, 200);
                    t = -32768 + (i / 32) * 2048 + $urandom_range(0, 200);
                    w = $urandom_range(16, 1800);
                    h = $urandom_range(16, 1800);
                end
                px[i] = l;
                py[i] = t;
                pw[i] = w;
                ph[i] = h;
            end
            else if (pick == 0)
            begin
                l = $urandom;
                t = $urandom;
                w = $urandom;
                h = $urandom;
            end
            else if (pick < 8)
            begin
                l = -32768 + $urandom_range(0, 31) * 2048 + $urandom_range(0, 200);
                t = -32768 + $urandom_range(10, 31) * 2048 + $urandom_range(0, 200);
                w = $urandom_range(16, 1800);
                h = $urandom_range(16, 1800);
            end
            else
            begin
                src = $urandom_range(0, 299);
                l = px[src] + $urandom_range(0, 64) - 32;
                t = py[src] + $urandom_range(0, 64) - 32;
                w = pw[src];
                h = ph[src];
            end
            send_box(l, t, w, h, i == len - 1);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames under the reset overlap limit
        send_box(0, 0, 160, 160, 1'b0);
        send_box(0, 0, 160, 160, 1'b0);                // identical box
        send_box(160, 0, 160, 160, 1'b0);              // touching edge
        send_box(-32768, -32768, 0, 0, 1'b0);          // zero area
        send_box(-32768, -32768, 0, 0, 1'b0);          // zero union
        send_box(32767, 32767, 65535, 65535, 1'b0);    // far corner, largest size
        send_box(-32768, -32768, 65535, 65535, 1'b0);  // covers every earlier box but the far corner
        send_box(16, 0, 160, 160, 1'b0);               // heavy partial overlap
        send_box(-100, 0, 160, 160, 1'b1);             // light overlap, closes frame
        send_box(5, 5, 65535, 0, 1'b1);                // single-box frame
        send_box(-1, -1, 1, 1, 1'b0);
        send_box(-1, -1, 1, 1, 1'b1);

        start_phase(0);
        run_clustered_frames(200);
        start_phase(65535);
        run_clustered_frames(200);
        start_phase($urandom_range(16384, 49152));
        run_crowded_frame(1040);
        start_phase($urandom_range(0, 65535));
        run_clustered_frames(110);

        in_valid <= 1'b0;
        wait_drained();
        repeat (300) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
